@@ hw/rtl/mpsd_pkg.sv @@
package mpsd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SLOT_COUNT   = 8;
    localparam int SAMPLE_W     = 32;
    localparam int OUT_W        = 16;
    localparam int COUNT_W      = 4;
    localparam int POS_W        = $clog2(MAX_CHANNELS);
    localparam int ROLE_W       = 4;
    localparam int SUM_W        = SAMPLE_W + 3;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    typedef enum logic [ROLE_W-1:0] {
        ROLE_FL  = 4'd0,
        ROLE_FR  = 4'd1,
        ROLE_CTR = 4'd2,
        ROLE_SUB = 4'd3,
        ROLE_BL  = 4'd4,
        ROLE_BR  = 4'd5,
        ROLE_SL  = 4'd6,
        ROLE_SR  = 4'd7
    } t_role;

    typedef enum logic [1:0] {
        MODE_16 = 2'd0,
        MODE_24 = 2'd1,
        MODE_32 = 2'd2
    } t_width_mode;

    typedef enum logic [1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_SAMPLE_WIDTH  = 2'd1,
        CFG_CHANNEL_ROLES = 2'd2
    } t_cfg_index;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [SLOT_COUNT-1:0] t_slot_vec;

    typedef struct packed {
        logic        mono;
        logic [1:0]  mode;
    } t_mix_ctl;

endpackage

@@ hw/rtl/mpsd_mix.sv @@
module mpsd_mix
    import mpsd_pkg::*;
(
    input  t_slot_vec               i_slots,
    input  t_mix_ctl                i_ctl,
    output logic signed [OUT_W-1:0] o_left,
    output logic signed [OUT_W-1:0] o_right
);

    function automatic logic signed [SUM_W-1:0] ext(input t_sample v);
        return signed'({{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v});
    endfunction

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end else begin
            c = v;
        end
        return c[OUT_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] common;
    logic signed [SUM_W-1:0] l_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] l_shr;
    logic signed [SUM_W-1:0] r_shr;
    logic [4:0]              sh;

    always_comb begin
        case (i_ctl.mode)
            MODE_24: sh = 5'd8;
            MODE_32: sh = 5'd16;
            default: sh = 5'd0;
        endcase
    end

    always_comb begin
        common = ext(i_slots[POS_W'(ROLE_CTR)]) + ext(i_slots[POS_W'(ROLE_SUB)]);
        if (i_ctl.mono) begin
            l_sum = ext(i_slots[POS_W'(ROLE_FL)]);
            r_sum = l_sum;
        end else begin
            l_sum = common + ext(i_slots[POS_W'(ROLE_FL)]) + ext(i_slots[POS_W'(ROLE_BL)])
                  + ext(i_slots[POS_W'(ROLE_SL)]);
            r_sum = common + ext(i_slots[POS_W'(ROLE_FR)]) + ext(i_slots[POS_W'(ROLE_BR)])
                  + ext(i_slots[POS_W'(ROLE_SR)]);
        end
        l_shr   = l_sum >>> sh;
        r_shr   = r_sum >>> sh;
        o_left  = sat(l_shr);
        o_right = sat(r_shr);
    end

endmodule

@@ hw/rtl/multichannel_pcm_stereo_downmix.sv @@
// Interleaved multichannel PCM to stereo downmix.
// Input channel: one channel sample per beat on i_sample_word (i_valid/o_stall).
// Each channel position has a 4-bit role from channel_roles; the sample is
// sign-extended (16/24/32 bits) into that role's slot. On the frame's last
// channel one stereo pair leaves on o_left_out/o_right_out (o_valid/i_stall):
// L = FL+CTR+SUB+BL+SL, R = FR+CTR+SUB+BR+SR, shifted right by 0/8/16 and
// saturated to 16 bits. Mono frames put FL on both sides.
// Configuration: i_cfg_valid/o_cfg_ready write port, ready always high;
// index 0 channel_count, 1 sample_width_mode, 2 channel_roles. Write only idle.
// Throughput: one sample per cycle while o_stall is low. A result becomes
// valid once the last sample of a frame has passed the snapshot register,
// then the result register holding the five-term add, shift and saturate.
// Stall: a held result keeps its value; the snapshot stage fills, then
// o_stall rises until the result is taken.
// Reset: slots cleared, position zero, registers back to 2 channels,
// 16-bit samples, roles FL FR CTR SUB BL BR SL SR; no result pending.
module multichannel_pcm_stereo_downmix
    import mpsd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_W-1:0]     i_sample_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_left_out,
    output logic signed [OUT_W-1:0] o_right_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [SAMPLE_W-1:0]     i_cfg_data
);

    logic [COUNT_W-1:0]        r_count;
    logic [1:0]                r_mode;
    logic [SAMPLE_W-1:0]       r_roles;
    t_slot_vec                 r_slots;
    t_slot_vec                 n_slots;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          n_pos;

    logic                      r_a_valid;
    t_slot_vec                 r_a_slots;
    t_mix_ctl                  r_a_ctl;

    logic                      r_o_valid;
    logic signed [OUT_W-1:0]   r_left;
    logic signed [OUT_W-1:0]   r_right;

    logic                      in_fire;
    logic                      a_adv;
    logic                      count_ok;
    logic                      is_last;
    logic [ROLE_W-1:0]         role;
    t_sample                   widened;
    t_slot_vec                 merged;
    logic signed [OUT_W-1:0]   mix_left;
    logic signed [OUT_W-1:0]   mix_right;

    assign a_adv       = !r_o_valid || !i_stall;
    assign o_stall     = r_a_valid && !a_adv;
    assign in_fire     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

    assign count_ok = (r_count != '0) && (r_count <= COUNT_W'(MAX_CHANNELS));
    assign role     = r_roles[r_pos*ROLE_W +: ROLE_W];
    assign is_last  = count_ok && !((COUNT_W'(r_pos) + COUNT_W'(1)) < r_count);

    always_comb begin
        case (r_mode)
            MODE_16: widened = {{(SAMPLE_W-16){i_sample_word[15]}}, i_sample_word[15:0]};
            MODE_24: widened = {{(SAMPLE_W-24){i_sample_word[23]}}, i_sample_word[23:0]};
            MODE_32: widened = i_sample_word;
            default: widened = '0;
        endcase
    end

    always_comb begin
        merged = r_slots;
        if (role < ROLE_W'(SLOT_COUNT)) begin
            merged[role[POS_W-1:0]] = widened;
        end
    end

    always_comb begin
        n_slots = r_slots;
        n_pos   = r_pos;
        if (in_fire) begin
            if (!count_ok) begin
                n_pos = '0;
            end else if (is_last) begin
                n_slots = '0;
                n_pos   = '0;
            end else begin
                n_slots = merged;
                n_pos   = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(2);
            r_mode  <= MODE_16;
            r_roles <= 32'h7654_3210;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_SAMPLE_WIDTH:  r_mode  <= i_cfg_data[1:0];
                CFG_CHANNEL_ROLES: r_roles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_pos   <= '0;
        end else begin
            r_slots <= n_slots;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire && is_last) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && is_last) begin
            r_a_slots    <= merged;
            r_a_ctl.mono <= (r_count == COUNT_W'(1));
            r_a_ctl.mode <= r_mode;
        end
    end

    mpsd_mix u_mix (
        .i_slots (r_a_slots),
        .i_ctl   (r_a_ctl),
        .o_left  (mix_left),
        .o_right (mix_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_adv) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_valid) begin
            r_left  <= mix_left;
            r_right <= mix_right;
        end
    end

    a_bad_count_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !count_ok) |=> (r_pos == '0))
        else $error("position not reset after sample with invalid channel count");

    a_last_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_last) |=> (r_a_valid && r_slots == '0 && r_pos == '0))
        else $error("frame end did not snapshot and clear slots");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_slots)))
        else $error("snapshot lost while result stalled");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_a_valid))
        else $error("result appeared without a snapshot");

endmodule

@@ dv/tb_multichannel_pcm_stereo_downmix.sv @@
module tb_multichannel_pcm_stereo_downmix
    import mpsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CFG_UNMAPPED  = 2'd3;
    localparam logic [1:0]  MODE_RSVD     = 2'd3;
    localparam logic [31:0] ROLES_DEFAULT = 32'h7654_3210;
    localparam int          PIPE_SETTLE   = 6;
    localparam int          WATCHDOG_MAX  = 2000;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } t_mix_pair;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    o_stall;
    logic [SAMPLE_W-1:0]     i_sample_word = '0;
    logic                    o_valid;
    logic                    i_stall       = 1'b0;
    logic signed [OUT_W-1:0] o_left_out;
    logic signed [OUT_W-1:0] o_right_out;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index   = '0;
    logic [SAMPLE_W-1:0]     i_cfg_data    = '0;

    // predictor state
    logic [COUNT_W-1:0] cfg_count = 4'd2;
    logic [1:0]         cfg_mode  = MODE_16;
    logic [31:0]        cfg_roles = ROLES_DEFAULT;
    longint             mix_slot[SLOT_COUNT] = '{default: 0};
    logic [POS_W-1:0]   chan_pos  = '0;

    t_mix_pair expected_pairs[$];
    int        mismatch_count = 0;
    bit        idle_en        = 1'b1;
    int        stall_left     = 0;
    bit        stall_now      = 1'b0;
    int        quiet_cycles   = 0;

    multichannel_pcm_stereo_downmix u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_word (i_sample_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [OUT_W-1:0] shift_sat16(input longint s, input int sh);
        longint v;
        v = s >>> sh;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[OUT_W-1:0];
    endfunction

    function automatic void downmix_step(input logic [SAMPLE_W-1:0] w);
        longint    v;
        int        sh;
        logic [3:0] role;
        longint    l;
        longint    r;
        t_mix_pair p;
        if (cfg_count == 0 || cfg_count > MAX_CHANNELS) begin
            chan_pos = '0;
            return;
        end
        case (cfg_mode)
            MODE_16: begin v = $signed(w[15:0]); sh = 0;  end
            MODE_24: begin v = $signed(w[23:0]); sh = 8;  end
            MODE_32: begin v = $signed(w);       sh = 16; end
            default: begin v = 0;                sh = 0;  end
        endcase
        role = cfg_roles[4*chan_pos +: 4];
        if (role < SLOT_COUNT)
            mix_slot[role[POS_W-1:0]] = v;
        if (int'(chan_pos) + 1 < int'(cfg_count)) begin
            chan_pos = chan_pos + 1'b1;
            return;
        end
        if (cfg_count == 1) begin
            l = mix_slot[POS_W'(ROLE_FL)];
            r = l;
        end else begin
            l = mix_slot[POS_W'(ROLE_FL)] + mix_slot[POS_W'(ROLE_CTR)]
              + mix_slot[POS_W'(ROLE_SUB)] + mix_slot[POS_W'(ROLE_BL)]
              + mix_slot[POS_W'(ROLE_SL)];
            r = mix_slot[POS_W'(ROLE_FR)] + mix_slot[POS_W'(ROLE_CTR)]
              + mix_slot[POS_W'(ROLE_SUB)] + mix_slot[POS_W'(ROLE_BR)]
              + mix_slot[POS_W'(ROLE_SR)];
        end
        p.left  = shift_sat16(l, sh);
        p.right = shift_sat16(r, sh);
        expected_pairs.push_back(p);
        mix_slot = '{default: 0};
        chan_pos = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_now  = idle_en && ($urandom_range(0, 2) == 0);
            stall_left = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        stall_left--;
        i_stall <= stall_now;
    end

    always @(posedge i_clk) begin
        t_mix_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair L=%0d R=%0d",
                                          o_left_out, o_right_out));
            end else begin
                want = expected_pairs.pop_front();
                if (o_left_out !== want.left)
                    report_mismatch($sformatf("left_out got %0d want %0d",
                                              o_left_out, want.left));
                if (o_right_out !== want.right)
                    report_mismatch($sformatf("right_out got %0d want %0d",
                                              o_right_out, want.right));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
            || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] w);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample_word <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        downmix_step(w);
    endtask

    task automatic wait_mix_idle();
        i_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (last)
            i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CHANNEL_COUNT: cfg_count = val[3:0];
            CFG_SAMPLE_WIDTH:  cfg_mode  = val[1:0];
            CFG_CHANNEL_ROLES: cfg_roles = val;
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk; only the low bits count
    task automatic program_mix(input logic [3:0] cnt, input logic [1:0] mode,
                               input logic [31:0] roles);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(CFG_CHANNEL_COUNT, {junk[31:4], cnt}, 1'b0);
        junk = $urandom();
        write_reg(CFG_SAMPLE_WIDTH, {junk[31:2], mode}, 1'b0);
        write_reg(CFG_CHANNEL_ROLES, roles, 1'b1);
    endtask

    function automatic logic [31:0] rand_sample();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 7))
            0: w[15:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: w[23:0] = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            2: w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: w = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            4: w[31:8] = {24{w[7]}};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rand_roles();
        logic [31:0] roles;
        roles = $urandom();
        if ($urandom_range(0, 5) != 0) begin
            for (int c = 0; c < MAX_CHANNELS; c++)
                if ($urandom_range(0, 3) != 0)
                    roles[4*c +: 4] = {1'b0, roles[4*c +: 3]};
        end
        return roles;
    endfunction

    task automatic test_reset_defaults();
        send_sample(32'h0000_7FFF);
        send_sample(32'h0000_8000);
        send_sample(32'hFFFF_8000);
        send_sample(32'h1234_7FFF);
    endtask

    task automatic test_width_modes();
        wait_mix_idle();
        program_mix(4'd3, MODE_32, 32'h0000_0320);
        repeat (3) send_sample(32'h8000_0000);
        wait_mix_idle();
        program_mix(4'd2, MODE_24, ROLES_DEFAULT);
        send_sample(32'hAB80_0000);
        send_sample(32'h007F_FFFF);
        wait_mix_idle();
        program_mix(4'd2, MODE_RSVD, ROLES_DEFAULT);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_mono();
        wait_mix_idle();
        program_mix(4'd1, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_1234);
        wait_mix_idle();
        program_mix(4'd1, MODE_24, 32'h7654_321F);
        send_sample(32'h00FF_FFFF);
        wait_mix_idle();
        program_mix(4'd1, MODE_16, 32'h0000_0001);
        send_sample(32'h0000_7FFF);
    endtask

    task automatic test_bad_count();
        wait_mix_idle();
        program_mix(4'd3, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_0100);
        wait_mix_idle();
        program_mix(4'd0, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_7FFF);
        wait_mix_idle();
        program_mix(4'd15, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_8000);
        wait_mix_idle();
        program_mix(4'd2, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_0200);
        send_sample(32'h0000_0300);
    endtask

    task automatic test_count_lowered();
        wait_mix_idle();
        program_mix(4'd8, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_1000);
        send_sample(32'h0000_2000);
        send_sample(32'h0000_3000);
        wait_mix_idle();
        write_reg(CFG_UNMAPPED, $urandom(), 1'b0);
        program_mix(4'd2, MODE_16, ROLES_DEFAULT);
        send_sample(32'h0000_4000);
    endtask

    task automatic test_role_overwrite();
        wait_mix_idle();
        program_mix(4'd3, MODE_16, 32'h0000_0000);
        send_sample(32'h0000_0100);
        send_sample(32'h0000_0200);
        send_sample(32'h0000_8000);
    endtask

    task automatic test_random_frames(input int target);
        int          sent;
        int          phase;
        int          beats;
        int          pick;
        logic [3:0]  cnt;
        sent  = 0;
        phase = 0;
        while (sent < target) begin
            wait_mix_idle();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                cnt = 4'd0;
            else if (pick == 1)
                cnt = 4'($urandom_range(9, 15));
            else if (pick < 5)
                cnt = 4'd1;
            else if (pick < 8)
                cnt = 4'd8;
            else
                cnt = 4'($urandom_range(2, 7));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNMAPPED, $urandom(), 1'b0);
            program_mix(cnt, ($urandom_range(0, 9) == 0) ? MODE_RSVD
                                                          : 2'($urandom_range(0, 2)),
                        rand_roles());
            beats = (cnt == 0 || cnt > MAX_CHANNELS) ? $urandom_range(1, 4)
                                                     : $urandom_range(4, 40);
            for (int k = 0; k < beats; k++) begin
                // hold off mid-phase until the pipe drains
                if (phase % 6 == 5 && k == beats / 2)
                    wait_mix_idle();
                send_sample(rand_sample());
                if (cnt != 0 && cnt <= MAX_CHANNELS)
                    sent++;
            end
            phase++;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_width_modes();
        test_mono();
        test_bad_count();
        test_count_lowered();
        test_role_overwrite();
        test_random_frames(900);
        idle_en = 1'b0;
        test_random_frames(200);
        wait_mix_idle();
        if (mismatch_count == 0 && expected_pairs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mpsd_pkg.sv
hw/rtl/mpsd_mix.sv
hw/rtl/multichannel_pcm_stereo_downmix.sv
dv/tb_multichannel_pcm_stereo_downmix.sv
